### rtl/core/crw_pkg.sv
// shared types, constants and register codes of the centered rmsprop update
// no dependencies
package crw_pkg;

  // weight store depth
  localparam int WEIGHT_COUNT_DEF = 1024;

  // field widths
  localparam int INDEX_W   = 10;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // pipeline depth of the shared arithmetic units
  localparam int SQRT_STEPS = 32;
  localparam int NUM_W      = 48;
  localparam int DIV_STEPS  = NUM_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_DECAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_DECAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 3'd4;

  // register reset values
  localparam logic [15:0] GRAD_DECAY_RST   = 16'd62259;
  localparam logic [15:0] SQUARE_DECAY_RST = 16'd62259;
  localparam logic [15:0] DELTA_DECAY_RST  = 16'd58982;
  localparam logic [31:0] STEP_RATE_RST    = 32'd429497;
  localparam logic [15:0] EPSILON_RST      = 16'd7;

  // per-item data carried alongside the root and quotient units
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               inr;
    logic               neg;
    logic [31:0]        gmag;
    logic signed [31:0] mom;
  } side_t;

endpackage

### rtl/core/crw_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on crw_pkg
module crw_sqrt
  import crw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  logic [63:0]        in_rad_i,
  input  side_t              in_side_i,
  input  logic [INDEX_W-1:0] probe_idx_i,
  output logic               hit_o,
  output logic               out_vld_o,
  output logic [31:0]        out_root_o,
  output side_t              out_side_o
);

  logic [SQRT_STEPS-1:0] vld_q;
  logic [63:0]           rad_q [SQRT_STEPS];
  logic [63:0]           res_q [SQRT_STEPS];
  logic [63:0]           rad_d [SQRT_STEPS];
  logic [63:0]           res_d [SQRT_STEPS];
  side_t                 side_q [SQRT_STEPS];

  // one trial subtract per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] rad_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    if (k == 0) begin : g_first
      assign rad_in = in_rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rad_in = rad_q[k-1];
      assign res_in = res_q[k-1];
    end
    assign trial = res_in + Bit;
    always_comb begin
      if (rad_in >= trial) begin
        rad_d[k] = rad_in - trial;
        res_d[k] = (res_in >> 1) + Bit;
      end else begin
        rad_d[k] = rad_in;
        res_d[k] = res_in >> 1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], in_vld_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    side_q[0] <= in_side_i;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rad_q[k] <= rad_d[k];
      res_q[k] <= res_d[k];
    end
  end

  // in-flight index match
  always_comb begin
    hit_o = 1'b0;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (vld_q[k] && side_q[k].inr && (side_q[k].idx == probe_idx_i)) begin
        hit_o = 1'b1;
      end
    end
  end

  assign out_vld_o  = vld_q[SQRT_STEPS-1];
  assign out_root_o = res_q[SQRT_STEPS-1][31:0];
  assign out_side_o = side_q[SQRT_STEPS-1];

endmodule

### rtl/core/crw_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on crw_pkg
module crw_div
  import crw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  logic [NUM_W-1:0]   in_num_i,
  input  logic [31:0]        in_den_i,
  input  side_t              in_side_i,
  input  logic [INDEX_W-1:0] probe_idx_i,
  output logic               hit_o,
  output logic               out_vld_o,
  output logic [NUM_W-1:0]   out_quo_o,
  output side_t              out_side_o
);

  logic [DIV_STEPS-1:0] vld_q;
  logic [NUM_W-1:0]     nq_q  [DIV_STEPS];
  logic [31:0]          rem_q [DIV_STEPS];
  logic [31:0]          den_q [DIV_STEPS];
  logic [NUM_W-1:0]     nq_d  [DIV_STEPS];
  logic [31:0]          rem_d [DIV_STEPS];
  logic [31:0]          den_d [DIV_STEPS];
  side_t                side_q [DIV_STEPS];

  // dividend shifts out the top, quotient bits shift in at the bottom
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0] nq_in;
    logic [31:0]      rem_in;
    logic [32:0]      trial;
    if (k == 0) begin : g_first
      assign nq_in    = in_num_i;
      assign rem_in   = '0;
      assign den_d[k] = in_den_i;
    end else begin : g_next
      assign nq_in    = nq_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_d[k] = den_q[k-1];
    end
    assign trial = {rem_in, nq_in[NUM_W-1]};
    always_comb begin
      if (trial >= {1'b0, den_d[k]}) begin
        rem_d[k] = 32'(trial - {1'b0, den_d[k]});
        nq_d[k]  = {nq_in[NUM_W-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[31:0];
        nq_d[k]  = {nq_in[NUM_W-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STEPS-2:0], in_vld_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    side_q[0] <= in_side_i;
    for (int k = 1; k < DIV_STEPS; k++) begin
      side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      nq_q[k]  <= nq_d[k];
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_d[k];
    end
  end

  // in-flight index match
  always_comb begin
    hit_o = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (vld_q[k] && side_q[k].inr && (side_q[k].idx == probe_idx_i)) begin
        hit_o = 1'b1;
      end
    end
  end

  assign out_vld_o  = vld_q[DIV_STEPS-1];
  assign out_quo_o  = nq_q[DIV_STEPS-1];
  assign out_side_o = side_q[DIV_STEPS-1];

endmodule

### rtl/core/centered_rmsprop_weight_update.sv
// top level of the centered rmsprop weight update pipeline
// depends on crw_pkg, crw_sqrt, crw_div
//
// channel   direction  signals                            handshake
// item in   input      start, weight_index_i, gradient_i  start & !busy
// result    output     done_o, delta_weight_o             done_o, one cycle
// config    input      cfg_we_i, cfg_idx_i, cfg_data_i    cfg_we_i
//
// one item per cycle while busy is low; the result passes 4 update stages,
// 32 root stages, 48 quotient stages, 2 scaling stages
// after reset busy stays high while the stores clear
// busy is also high while an in-range item of the same weight is in flight
// the result cannot be held off; the pipeline never stalls once an item is in
module centered_rmsprop_weight_update
  import crw_pkg::*;
#(
  parameter int WEIGHT_COUNT = WEIGHT_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [INDEX_W-1:0]   weight_index_i,
  input  logic signed [31:0]   gradient_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 done_o,
  output logic signed [31:0]   delta_weight_o
);

  localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam logic [16:0] WcLimit = 17'(WEIGHT_COUNT);
  localparam logic [AW-1:0] LastAddr = AW'(WEIGHT_COUNT - 1);

  // configuration registers
  logic [15:0] gd_q, sd_q, dd_q, eps_q;
  logic [31:0] sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gd_q  <= GRAD_DECAY_RST;
      sd_q  <= SQUARE_DECAY_RST;
      dd_q  <= DELTA_DECAY_RST;
      sr_q  <= STEP_RATE_RST;
      eps_q <= EPSILON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRAD_DECAY:   gd_q  <= cfg_data_i[15:0];
        REG_SQUARE_DECAY: sd_q  <= cfg_data_i[15:0];
        REG_DELTA_DECAY:  dd_q  <= cfg_data_i[15:0];
        REG_STEP_RATE:    sr_q  <= cfg_data_i;
        REG_EPSILON:      eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == LastAddr) begin
        clr_q <= 1'b0;
      end
    end
  end

  // pipeline signals
  logic               v1_q, v2_q, v3_q, v4_q, ve_q, done_q;
  logic [INDEX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q, idx_o_q;
  logic               inr1_q, inr2_q, inr3_q, inr4_q, inr_o_q;
  side_t              side_e_q;
  logic               sqrt_hit, div_hit, hit, in_range, accept;

  // accept and hazard check
  assign in_range = (17'(weight_index_i) < WcLimit);
  always_comb begin
    hit = sqrt_hit | div_hit;
    if (v1_q && inr1_q && idx1_q == weight_index_i) hit = 1'b1;
    if (v2_q && inr2_q && idx2_q == weight_index_i) hit = 1'b1;
    if (v3_q && inr3_q && idx3_q == weight_index_i) hit = 1'b1;
    if (v4_q && inr4_q && idx4_q == weight_index_i) hit = 1'b1;
    if (ve_q && side_e_q.inr && side_e_q.idx == weight_index_i) hit = 1'b1;
    if (done_q && inr_o_q && idx_o_q == weight_index_i) hit = 1'b1;
  end
  assign busy   = clr_q | (in_range & hit);
  assign accept = start & ~busy;

  // per-weight stores
  logic signed [31:0] mg_mem [WEIGHT_COUNT];
  logic [63:0]        ms_mem [WEIGHT_COUNT];
  logic signed [31:0] ld_mem [WEIGHT_COUNT];
  logic signed [31:0] mg_rd_q, ld_rd_q;
  logic [63:0]        ms_rd_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  logic               mg_we, ms_we, ld_we;
  logic [AW-1:0]      mg_wa, ms_wa, ld_wa;
  logic signed [31:0] mg_wd, ld_wd;
  logic [63:0]        ms_wd;
  logic signed [31:0] mg3_q, dw_q;
  logic [63:0]        ms4_q;

  assign rd_en   = accept & in_range;
  assign rd_addr = AW'(weight_index_i);

  assign mg_we = clr_q | (v3_q & inr3_q);
  assign mg_wa = clr_q ? clr_cnt_q : AW'(idx3_q);
  assign mg_wd = clr_q ? '0 : mg3_q;
  assign ms_we = clr_q | (v4_q & inr4_q);
  assign ms_wa = clr_q ? clr_cnt_q : AW'(idx4_q);
  assign ms_wd = clr_q ? '0 : ms4_q;
  assign ld_we = clr_q | (done_q & inr_o_q);
  assign ld_wa = clr_q ? clr_cnt_q : AW'(idx_o_q);
  assign ld_wd = clr_q ? '0 : dw_q;

  always_ff @(posedge clk_i) begin
    if (mg_we) mg_mem[mg_wa] <= mg_wd;
    if (rd_en) mg_rd_q <= mg_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (ms_we) ms_mem[ms_wa] <= ms_wd;
    if (rd_en) ms_rd_q <= ms_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (ld_we) ld_mem[ld_wa] <= ld_wd;
    if (rd_en) ld_rd_q <= ld_mem[rd_addr];
  end

  // stage 1: item registers, store data arrives
  logic signed [31:0] g1_q;
  always_ff @(posedge clk_i) begin
    idx1_q <= weight_index_i;
    inr1_q <= in_range;
    g1_q   <= gradient_i;
  end

  // stage 1 products
  logic [16:0]        cgd, csd;
  logic signed [48:0] pa_d, pl_d;
  logic signed [49:0] pb_d;
  logic [31:0]        gmag_d;
  logic [63:0]        g2_d;
  assign cgd    = 17'h10000 - {1'b0, gd_q};
  assign csd    = 17'h10000 - {1'b0, sd_q};
  assign pa_d   = $signed({1'b0, gd_q}) * mg_rd_q;
  assign pb_d   = $signed({1'b0, cgd}) * g1_q;
  assign pl_d   = $signed({1'b0, dd_q}) * ld_rd_q;
  assign gmag_d = g1_q[31] ? 32'(-g1_q) : 32'(g1_q);
  assign g2_d   = 64'(gmag_d) * 64'(gmag_d);

  // stage 2
  logic signed [48:0] pa2_q, pl2_q;
  logic signed [49:0] pb2_q;
  logic [31:0]        gmag2_q;
  logic               neg2_q;
  logic [63:0]        g22_q, ms2_q;
  always_ff @(posedge clk_i) begin
    idx2_q  <= idx1_q;
    inr2_q  <= inr1_q;
    pa2_q   <= pa_d;
    pb2_q   <= pb_d;
    pl2_q   <= pl_d;
    gmag2_q <= gmag_d;
    neg2_q  <= g1_q[31];
    g22_q   <= g2_d;
    ms2_q   <= ms_rd_q;
  end

  // stage 2: new gradient average, decayed delta, square partial products
  logic signed [50:0] mg_sum;
  logic [47:0]        a0_d, a1_d;
  logic [48:0]        b0_d, b1_d;
  assign mg_sum = 51'(pa2_q) + 51'(pb2_q);
  assign a0_d   = 48'(sd_q) * 48'(ms2_q[31:0]);
  assign a1_d   = 48'(sd_q) * 48'(ms2_q[63:32]);
  assign b0_d   = 49'(csd) * 49'(g22_q[31:0]);
  assign b1_d   = 49'(csd) * 49'(g22_q[63:32]);

  // stage 3
  logic signed [31:0] mom3_q;
  logic [47:0]        a0_q, a1_q;
  logic [48:0]        b0_q, b1_q;
  logic [31:0]        gmag3_q;
  logic               neg3_q;
  always_ff @(posedge clk_i) begin
    idx3_q  <= idx2_q;
    inr3_q  <= inr2_q;
    mg3_q   <= mg_sum[47:16];
    mom3_q  <= pl2_q[47:16];
    a0_q    <= a0_d;
    a1_q    <= a1_d;
    b0_q    <= b0_d;
    b1_q    <= b1_d;
    gmag3_q <= gmag2_q;
    neg3_q  <= neg2_q;
  end

  // stage 3: new squared average, square of the new gradient average
  logic [81:0] ms_sum;
  logic [31:0] mgmag;
  logic [63:0] mg2_d;
  assign ms_sum = {2'b0, a1_q, 32'b0} + 82'(a0_q) + {1'b0, b1_q, 32'b0} + 82'(b0_q);
  assign mgmag  = mg3_q[31] ? 32'(-mg3_q) : 32'(mg3_q);
  assign mg2_d  = 64'(mgmag) * 64'(mgmag);

  // stage 4
  logic [63:0]        mg2_4_q;
  logic signed [31:0] mom4_q;
  logic [31:0]        gmag4_q;
  logic               neg4_q;
  always_ff @(posedge clk_i) begin
    idx4_q  <= idx3_q;
    inr4_q  <= inr3_q;
    ms4_q   <= ms_sum[79:16];
    mg2_4_q <= mg2_d;
    mom4_q  <= mom3_q;
    gmag4_q <= gmag3_q;
    neg4_q  <= neg3_q;
  end

  // stage 4: variance clamped at zero plus epsilon
  logic [63:0] rad;
  side_t       side4;
  assign rad = ((ms4_q > mg2_4_q) ? (ms4_q - mg2_4_q) : 64'd0) + {32'b0, eps_q, 16'b0};
  assign side4 = '{idx: idx4_q, inr: inr4_q, neg: neg4_q, gmag: gmag4_q, mom: mom4_q};

  // root of the variance
  logic        sq_vld;
  logic [31:0] sq_root;
  side_t       sq_side;
  crw_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (v4_q),
    .in_rad_i    (rad),
    .in_side_i   (side4),
    .probe_idx_i (weight_index_i),
    .hit_o       (sqrt_hit),
    .out_vld_o   (sq_vld),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // gradient magnitude over the root, zero root taken as one
  logic [31:0]      den;
  logic             dv_vld;
  logic [NUM_W-1:0] quo;
  side_t            dv_side;
  assign den = (sq_root == '0) ? 32'd1 : sq_root;
  crw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (sq_vld),
    .in_num_i    ({sq_side.gmag, 16'b0}),
    .in_den_i    (den),
    .in_side_i   (sq_side),
    .probe_idx_i (weight_index_i),
    .hit_o       (div_hit),
    .out_vld_o   (dv_vld),
    .out_quo_o   (quo),
    .out_side_o  (dv_side)
  );

  // scaling products by the learning rate
  logic [47:0] qh_q;
  logic [31:0] ql_q;
  logic [63:0] ql_full;
  assign ql_full = 64'(quo[31:0]) * 64'(sr_q);
  always_ff @(posedge clk_i) begin
    qh_q     <= 48'(quo[47:32]) * 48'(sr_q);
    ql_q     <= ql_full[63:32];
    side_e_q <= dv_side;
  end

  // new delta with momentum, saturated
  logic [48:0]        scaled;
  logic signed [50:0] sg, nd;
  logic signed [31:0] nd_sat;
  assign scaled = 49'(qh_q) + 49'(ql_q);
  assign sg     = side_e_q.neg ? -$signed({2'b0, scaled}) : $signed({2'b0, scaled});
  assign nd     = 51'(side_e_q.mom) - sg;
  always_comb begin
    if (nd > 51'sd2147483647) begin
      nd_sat = 32'sh7fffffff;
    end else if (nd < -51'sd2147483648) begin
      nd_sat = 32'sh80000000;
    end else begin
      nd_sat = nd[31:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    dw_q    <= side_e_q.inr ? nd_sat : 32'sd0;
    idx_o_q <= side_e_q.idx;
    inr_o_q <= side_e_q.inr;
  end

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      ve_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      ve_q   <= dv_vld;
      done_q <= ve_q;
    end
  end

  assign done_o         = done_q;
  assign delta_weight_o = dw_q;

`ifndef SYNTHESIS
  // pipeline is empty while the stores clear
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !done_o && !v4_q && !sq_vld)
    else $error("result during clearing pass");

  // out-of-range items report zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !inr_o_q |-> delta_weight_o == 32'sd0)
    else $error("out-of-range item gave nonzero delta");

  // a read never meets the delta write-back of the same weight
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && ld_we && !clr_q |-> ld_wa != rd_addr)
    else $error("delta store read and write at same weight");

  // root unit latency
  a_sqrt_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ##32 sq_vld)
    else $error("root unit lost an item");

  // quotient unit latency
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> ##48 dv_vld)
    else $error("quotient unit lost an item");
`endif

endmodule

### bench/centered_rmsprop_weight_update_tb.sv
// self-checking bench for the centered rmsprop weight update block
// depends on crw_pkg and the centered_rmsprop_weight_update rtl
module centered_rmsprop_weight_update_tb;
  import crw_pkg::*;

  localparam int WCOUNT     = WEIGHT_COUNT_DEF;
  localparam int DRAIN      = 100;
  localparam int QUIET_MAX  = 3000;

  // tracks per-weight optimizer state and the queue of expected deltas
  class delta_scoreboard;
    int                 mean_grad [WCOUNT];
    longint unsigned    mean_sq   [WCOUNT];
    int                 prev_delta[WCOUNT];
    logic [15:0]        gd, sd, dd, eps;
    logic [31:0]        rate;
    logic signed [31:0] pending_deltas[$];
    int                 errors;
    int                 items;
    int                 results;

    function new();
      gd = GRAD_DECAY_RST; sd = SQUARE_DECAY_RST; dd = DELTA_DECAY_RST;
      rate = STEP_RATE_RST; eps = EPSILON_RST;
      foreach (mean_grad[i]) begin
        mean_grad[i] = 0; mean_sq[i] = 0; prev_delta[i] = 0;
      end
      errors = 0; items = 0; results = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_GRAD_DECAY:   gd = data[15:0];
        REG_SQUARE_DECAY: sd = data[15:0];
        REG_DELTA_DECAY:  dd = data[15:0];
        REG_STEP_RATE:    rate = data;
        REG_EPSILON:      eps = data[15:0];
        default: ;
      endcase
    endfunction

    // floor square root of a 64-bit value
    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // one accepted item: update the weight state and queue the delta
    function void note_item(logic [INDEX_W-1:0] idx, logic signed [31:0] grad);
      longint          g, mg, sg, mom, nd;
      longint unsigned gmag, g2, mgmag, mg2, ms, var_q, den, q, scaled;
      logic [127:0]    acc, prod;
      items++;
      if (idx >= WCOUNT) begin
        pending_deltas.push_back(0);
        return;
      end
      g = grad;
      mg = (longint'(gd) * mean_grad[idx] + longint'(65536 - gd) * g) >>> 16;
      mean_grad[idx] = int'(mg);
      gmag = (g < 0) ? -g : g;
      g2 = gmag * gmag;
      acc = {64'd0, mean_sq[idx]} * 128'(sd) + {64'd0, g2} * 128'(65536 - sd);
      ms = acc[79:16];
      mean_sq[idx] = ms;
      mgmag = (mg < 0) ? -mg : mg;
      mg2 = mgmag * mgmag;
      // negative variance clamps to zero before epsilon
      var_q = (ms > mg2) ? ms - mg2 : 0;
      var_q = var_q + (longint'(eps) << 16);
      den = int_root(var_q);
      if (den == 0) den = 1;
      q = (gmag << 16) / den;
      prod = {64'd0, q} * 128'(rate);
      scaled = prod[95:32];
      sg = (g < 0) ? -longint'(scaled) : longint'(scaled);
      mom = (longint'(dd) * prev_delta[idx]) >>> 16;
      nd = mom - sg;
      // saturate to the 32-bit range
      if (nd > 64'sd2147483647) nd = 64'sd2147483647;
      if (nd < -64'sd2147483648) nd = -64'sd2147483648;
      prev_delta[idx] = int'(nd);
      pending_deltas.push_back(nd[31:0]);
    endfunction

    function void check_result(logic signed [31:0] actual);
      logic signed [31:0] want;
      results++;
      if (pending_deltas.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      want = pending_deltas.pop_front();
      if (want !== actual) begin
        $display("%0t: delta_weight mismatch, expected %0d, actual %0d",
                 $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i, rst_ni;
  logic                 start, busy;
  logic [INDEX_W-1:0]   weight_index_i;
  logic signed [31:0]   gradient_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;
  logic                 done_o;
  logic signed [31:0]   delta_weight_o;

  delta_scoreboard sb;
  int  quiet;
  int  phases;
  bit  idling;
  logic [INDEX_W-1:0] pool[32];

  centered_rmsprop_weight_update DUT (
    .clk_i, .rst_ni, .start, .busy, .weight_index_i, .gradient_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .delta_weight_o
  );

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: accepted items, config writes, results and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.configure(cfg_idx_i, cfg_data_i);
      if (start && !busy) begin
        sb.note_item(weight_index_i, gradient_i);
      end
      if (done_o) begin
        sb.check_result(delta_weight_o);
      end
      if ((start && !busy) || done_o) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // present one item and hold it until accepted
  task automatic send_item(logic [INDEX_W-1:0] idx, logic signed [31:0] grad);
    start <= 1'b1;
    weight_index_i <= idx;
    gradient_i <= grad;
    do @(posedge clk_i); while (busy);
  endtask

  // random sender gap
  task automatic maybe_idle();
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending_deltas.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // write all five registers while idle
  task automatic write_regs(logic [15:0] g, logic [15:0] s, logic [15:0] d,
                            logic [31:0] r, logic [15:0] e);
    logic [31:0] vals[5];
    vals = '{32'(g), 32'(s), 32'(d), r, 32'(e)};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  function automatic logic signed [31:0] rand_gradient();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      3: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
    endcase
  endfunction

  // mostly a small set of weights so state builds up, else any weight
  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) send_item(pool[$urandom_range(0, 31)], rand_gradient());
      else send_item(INDEX_W'($urandom), rand_gradient());
      maybe_idle();
    end
  endtask

  initial begin
    sb = new();
    phases = 0;
    quiet = 0;
    idling = 1;
    rst_ni = 1'b0;
    start = 1'b0;
    weight_index_i = '0;
    gradient_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    foreach (pool[i]) pool[i] = INDEX_W'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes under reset settings
    send_item(0, 0);
    send_item(1023, 32'sh7fffffff);
    send_item(1022, 32'sh80000000);
    send_item(1023, -1);
    send_item(0, 1);
    // tiny repeated gradients round both averages to zero
    for (int i = 0; i < 5; i++) send_item(5, 1);
    for (int i = 0; i < 4; i++) send_item(7, (i % 2) ? 32'sh00400000 : -32'sh00400000);

    // no momentum, maximum rate, smallest nonzero epsilon: saturates
    write_regs(0, 0, 0, 32'hffffffff, 1);
    send_item(9, 32'sh7fffffff);
    send_item(10, 32'sh80000000);
    send_item(9, 32'sh7fffffff);
    send_item(11, 1);
    random_items(250);

    // full momentum, zero rate, largest epsilon
    write_regs(16'hffff, 16'hffff, 16'hffff, 0, 16'hffff);
    random_items(250);

    // back to the reset settings, with one full drain midway
    write_regs(GRAD_DECAY_RST, SQUARE_DECAY_RST, DELTA_DECAY_RST, STEP_RATE_RST,
               EPSILON_RST);
    random_items(150);
    wait_drained();
    random_items(150);

    // random settings
    for (int p = 0; p < 2; p++) begin
      write_regs(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                 16'($urandom_range(1, 65535)));
      random_items(200);
    end
    idling = 0;
    random_items(150);

    wait_drained();
    $display("covered %0d items and %0d results over %0d register settings",
             sb.items, sb.results, phases + 1);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
